### hdl/tmac_pkg.sv
package tmac_pkg;

    localparam int CHANNELS        = 5;
    localparam int SAMPLES_PER_SET = 5;
    localparam int POST_DIVIDE     = 4;
    localparam int NUM_OFFSETS     = 5;

    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 15;
    localparam int CNT_W     = 3;
    localparam int LEVEL_W   = 10;
    localparam int CC_W      = 8;
    localparam int OUT_W     = 11;
    localparam int CFG_W     = 10;
    localparam int DB_W      = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Trimmed mean: divide by (SAMPLES_PER_SET - 2), then by POST_DIVIDE, both
    // truncating, so one floor division by their product. Done as a multiply
    // by a rounded-up reciprocal; exact for every sum below 2**SUM_W.
    localparam int DIV_TOTAL   = (SAMPLES_PER_SET - 2) * POST_DIVIDE;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 31;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + DIV_TOTAL - 1) / DIV_TOTAL;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [CFG_W-1:0] OFFSET_CH0_RST = 10'd0;
    localparam logic [CFG_W-1:0] OFFSET_CH1_RST = 10'd521;
    localparam logic [CFG_W-1:0] OFFSET_CH2_RST = 10'd523;
    localparam logic [CFG_W-1:0] OFFSET_CH3_RST = 10'd454;
    localparam logic [CFG_W-1:0] OFFSET_CH4_RST = 10'd521;
    localparam logic [CFG_W-1:0] DEADBAND_RST   = 10'd15;
    localparam logic [CFG_W-1:0] CLAMP_RST      = 10'd300;
    localparam logic [DB_W-1:0]  DEBOUNCE_RST   = 8'd12;

    typedef enum logic [2:0] {
        REG_OFFSET_CH0  = 3'd0,
        REG_OFFSET_CH1  = 3'd1,
        REG_OFFSET_CH2  = 3'd2,
        REG_OFFSET_CH3  = 3'd3,
        REG_OFFSET_CH4  = 3'd4,
        REG_DEADBAND    = 3'd5,
        REG_CLAMP_LIMIT = 3'd6,
        REG_DEBOUNCE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] min_s;
        logic [SAMPLE_W-1:0] max_s;
        logic [CNT_W-1:0]    cnt;
    } stat_entry_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] held;
        logic [CC_W-1:0]    cc;
    } deb_entry_t;

endpackage

### hdl/trimmed_mean_adc_conditioner_core.sv
// Channel    Direction  Handshake                Payload
// s_axis     in         tvalid/tready            tuser: channel, tdata: sample
// m_axis     out        tvalid/tready            tuser: out_channel, tdata: level
// apb        in         psel/penable/pready      paddr/pwdata/prdata, 8 registers
//
// One beat per clock sustained while the skid register is empty; a completed set's
// result passes through stage registers v1_reg to v7_reg into the output register.
// The rate is set by the two read-modify-write loops on the statistics memory
// and on the debounce memory, each closed with a forwarding path.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// s_axis_tready drops only while the skid register holds a result.
module trimmed_mean_adc_conditioner_core (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [11:0] sample
    input  logic [7:0]                 s_axis_tuser,   // [2:0] channel

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [10:0] level (signed)
    output logic [7:0]                 m_axis_tuser,   // [2:0] out_channel

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tmac_pkg::ADDR_W-1:0] paddr,
    input  logic [tmac_pkg::DATA_W-1:0] pwdata,
    output logic [tmac_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CH_W     = tmac_pkg::CH_W;
    localparam int SAMPLE_W = tmac_pkg::SAMPLE_W;
    localparam int SUM_W    = tmac_pkg::SUM_W;
    localparam int CNT_W    = tmac_pkg::CNT_W;
    localparam int LEVEL_W  = tmac_pkg::LEVEL_W;
    localparam int CC_W     = tmac_pkg::CC_W;
    localparam int OUT_W    = tmac_pkg::OUT_W;
    localparam int CFG_W    = tmac_pkg::CFG_W;
    localparam int DB_W     = tmac_pkg::DB_W;
    localparam int IDX_W    = tmac_pkg::CH_IDX_W;
    localparam int PROD_W   = SUM_W + tmac_pkg::RECIP_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] offset_reg [tmac_pkg::NUM_OFFSETS];
    logic [CFG_W-1:0] deadband_reg;
    logic [CFG_W-1:0] clamp_reg;
    logic [DB_W-1:0]  debounce_reg;

    logic               cfg_wr;
    tmac_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tmac_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= tmac_pkg::OFFSET_CH0_RST;
            offset_reg[1] <= tmac_pkg::OFFSET_CH1_RST;
            offset_reg[2] <= tmac_pkg::OFFSET_CH2_RST;
            offset_reg[3] <= tmac_pkg::OFFSET_CH3_RST;
            offset_reg[4] <= tmac_pkg::OFFSET_CH4_RST;
            deadband_reg  <= tmac_pkg::DEADBAND_RST;
            clamp_reg     <= tmac_pkg::CLAMP_RST;
            debounce_reg  <= tmac_pkg::DEBOUNCE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                tmac_pkg::REG_OFFSET_CH0,
                tmac_pkg::REG_OFFSET_CH1,
                tmac_pkg::REG_OFFSET_CH2,
                tmac_pkg::REG_OFFSET_CH3,
                tmac_pkg::REG_OFFSET_CH4:
                    offset_reg[paddr[4:2]] <= pwdata[CFG_W-1:0];
                tmac_pkg::REG_DEADBAND:    deadband_reg <= pwdata[CFG_W-1:0];
                tmac_pkg::REG_CLAMP_LIMIT: clamp_reg    <= pwdata[CFG_W-1:0];
                tmac_pkg::REG_DEBOUNCE:    debounce_reg <= pwdata[DB_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            tmac_pkg::REG_OFFSET_CH0,
            tmac_pkg::REG_OFFSET_CH1,
            tmac_pkg::REG_OFFSET_CH2,
            tmac_pkg::REG_OFFSET_CH3,
            tmac_pkg::REG_OFFSET_CH4:
                prdata[CFG_W-1:0] = offset_reg[paddr[4:2]];
            tmac_pkg::REG_DEADBAND:    prdata[CFG_W-1:0] = deadband_reg;
            tmac_pkg::REG_CLAMP_LIMIT: prdata[CFG_W-1:0] = clamp_reg;
            tmac_pkg::REG_DEBOUNCE:    prdata[DB_W-1:0]  = debounce_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together on adv. The skid
    // register takes a result the output register cannot, and only a full
    // skid holds the pipeline.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic out_valid_reg;
    logic adv;
    logic in_beat;
    logic in_range;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_range      = s_axis_tuser[CH_W-1:0] < CH_W'(tmac_pkg::CHANNELS);

    // ------------------------------------------------------------------
    // Statistics memory: sum, min, max and sample count per channel
    // ------------------------------------------------------------------
    tmac_pkg::stat_entry_t stat_mem [tmac_pkg::CHANNELS];
    logic [tmac_pkg::CHANNELS-1:0] stat_vld_reg;
    tmac_pkg::stat_entry_t stat_rd_reg;
    tmac_pkg::stat_entry_t stat_fwd_reg;
    logic                  stat_fwd_vld_reg;
    logic [CH_W-1:0]       stat_fwd_ch_reg;

    logic                  v1_reg;
    logic [CH_W-1:0]       ch1_reg;
    logic [SAMPLE_W-1:0]   s1_reg;

    tmac_pkg::stat_entry_t stat_cur;
    tmac_pkg::stat_entry_t stat_next;
    logic [CNT_W:0]        cnt_inc;
    logic                  set_done;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stat_rd_reg <= stat_mem[s_axis_tuser[IDX_W-1:0]];
            ch1_reg     <= s_axis_tuser[CH_W-1:0];
            s1_reg      <= s_axis_tdata[SAMPLE_W-1:0];
            if (v1_reg)
            begin
                stat_mem[ch1_reg[IDX_W-1:0]] <= stat_next;
                stat_fwd_reg                 <= stat_next;
                stat_fwd_ch_reg              <= ch1_reg;
            end
        end
    end

    always_comb
    begin
        // Take the most recently written entry when it is the same channel.
        if (stat_fwd_vld_reg && stat_fwd_ch_reg == ch1_reg)
            stat_cur = stat_fwd_reg;
        else if (stat_vld_reg[ch1_reg[IDX_W-1:0]])
            stat_cur = stat_rd_reg;
        else
            stat_cur = '0;

        cnt_inc  = {1'b0, stat_cur.cnt} + (CNT_W+1)'(1);
        set_done = cnt_inc == (CNT_W+1)'(tmac_pkg::SAMPLES_PER_SET);

        if (stat_cur.cnt == '0)
        begin
            stat_next.sum   = SUM_W'(s1_reg);
            stat_next.min_s = s1_reg;
            stat_next.max_s = s1_reg;
        end
        else
        begin
            stat_next.sum   = stat_cur.sum + SUM_W'(s1_reg);
            stat_next.min_s = (s1_reg < stat_cur.min_s) ? s1_reg : stat_cur.min_s;
            stat_next.max_s = (s1_reg > stat_cur.max_s) ? s1_reg : stat_cur.max_s;
        end
        stat_next.cnt = set_done ? '0 : cnt_inc[CNT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Trim, then divide by reciprocal multiply
    // ------------------------------------------------------------------
    logic                v2_reg;
    logic [CH_W-1:0]     ch2_reg;
    logic [SUM_W-1:0]    sum2_reg;
    logic [SAMPLE_W-1:0] min2_reg;
    logic [SAMPLE_W-1:0] max2_reg;

    logic                v3_reg;
    logic [CH_W-1:0]     ch3_reg;
    logic [SUM_W-1:0]    trim3_reg;
    logic [SUM_W-1:0]    trim_next;

    logic                v4_reg;
    logic [CH_W-1:0]     ch4_reg;
    logic [LEVEL_W-1:0]  fresh4_reg;
    logic [PROD_W-1:0]   product;

    assign trim_next = sum2_reg - SUM_W'(min2_reg) - SUM_W'(max2_reg);
    assign product   = PROD_W'(trim3_reg) * PROD_W'(tmac_pkg::RECIP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ch2_reg    <= ch1_reg;
            sum2_reg   <= stat_next.sum;
            min2_reg   <= stat_next.min_s;
            max2_reg   <= stat_next.max_s;
            ch3_reg    <= ch2_reg;
            trim3_reg  <= trim_next;
            ch4_reg    <= ch3_reg;
            fresh4_reg <= product[tmac_pkg::RECIP_SHIFT +: LEVEL_W];
        end
    end

    // ------------------------------------------------------------------
    // Debounce memory: held level and change count per channel
    // ------------------------------------------------------------------
    tmac_pkg::deb_entry_t deb_mem [tmac_pkg::CHANNELS];
    logic [tmac_pkg::CHANNELS-1:0] deb_vld_reg;
    tmac_pkg::deb_entry_t deb_rd_reg;
    tmac_pkg::deb_entry_t deb_fwd_reg;
    logic                 deb_fwd_vld_reg;
    logic [CH_W-1:0]      deb_fwd_ch_reg;

    tmac_pkg::deb_entry_t deb_cur;
    tmac_pkg::deb_entry_t deb_next;
    logic [CC_W:0]        cc_inc;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deb_rd_reg <= deb_mem[ch3_reg[IDX_W-1:0]];
            if (v4_reg)
            begin
                deb_mem[ch4_reg[IDX_W-1:0]] <= deb_next;
                deb_fwd_reg                 <= deb_next;
                deb_fwd_ch_reg              <= ch4_reg;
            end
        end
    end

    always_comb
    begin
        if (deb_fwd_vld_reg && deb_fwd_ch_reg == ch4_reg)
            deb_cur = deb_fwd_reg;
        else if (deb_vld_reg[ch4_reg[IDX_W-1:0]])
            deb_cur = deb_rd_reg;
        else
            deb_cur = '0;

        cc_inc   = {1'b0, deb_cur.cc} + (CC_W+1)'(1);
        deb_next = deb_cur;
        // Equal level leaves the count as it is.
        if (deb_cur.held != fresh4_reg)
        begin
            if (cc_inc >= (CC_W+1)'(debounce_reg))
            begin
                deb_next.held = fresh4_reg;
                deb_next.cc   = '0;
            end
            else
            begin
                deb_next.cc = cc_inc[CC_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Offset, deadband, clamp
    // ------------------------------------------------------------------
    logic                    v5_reg;
    logic [CH_W-1:0]         ch5_reg;
    logic [LEVEL_W-1:0]      held5_reg;

    logic                    v6_reg;
    logic [CH_W-1:0]         ch6_reg;
    logic signed [OUT_W-1:0] diff6_reg;
    logic signed [OUT_W-1:0] diff_next;

    logic                    v7_reg;
    logic [CH_W-1:0]         ch7_reg;
    logic signed [OUT_W-1:0] val7_reg;
    logic signed [OUT_W-1:0] mag;
    logic signed [OUT_W-1:0] db_next;

    logic signed [OUT_W-1:0] lim;
    logic signed [OUT_W-1:0] res_level;

    assign diff_next = $signed({1'b0, held5_reg}) - $signed({1'b0, offset_reg[ch5_reg]});
    assign mag       = diff6_reg[OUT_W-1] ? -diff6_reg : diff6_reg;
    assign db_next   = (mag < $signed({1'b0, deadband_reg})) ? '0 : diff6_reg;
    assign lim       = $signed({1'b0, clamp_reg});

    always_comb
    begin
        res_level = val7_reg;
        // Channel 0 is reported unclamped.
        if (ch7_reg != '0)
        begin
            priority if (val7_reg > lim)
                res_level = lim;
            else if (val7_reg < -lim)
                res_level = -lim;
            else
                res_level = val7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ch5_reg   <= ch4_reg;
            held5_reg <= deb_next.held;
            ch6_reg   <= ch5_reg;
            diff6_reg <= diff_next;
            ch7_reg   <= ch6_reg;
            val7_reg  <= db_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage valids, memory valid bits, forwarding valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            v6_reg           <= 1'b0;
            v7_reg           <= 1'b0;
            stat_vld_reg     <= '0;
            deb_vld_reg      <= '0;
            stat_fwd_vld_reg <= 1'b0;
            deb_fwd_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_beat && in_range;
            v2_reg <= v1_reg && set_done;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            if (v1_reg)
            begin
                stat_vld_reg[ch1_reg[IDX_W-1:0]] <= 1'b1;
                stat_fwd_vld_reg                 <= 1'b1;
            end
            if (v4_reg)
            begin
                deb_vld_reg[ch4_reg[IDX_W-1:0]] <= 1'b1;
                deb_fwd_vld_reg                 <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid
    // ------------------------------------------------------------------
    logic [CH_W-1:0]         out_ch_reg;
    logic signed [OUT_W-1:0] out_level_reg;
    logic [CH_W-1:0]         skid_ch_reg;
    logic signed [OUT_W-1:0] skid_level_reg;
    logic                    push;
    logic                    pop;

    assign push = adv && v7_reg;
    assign pop  = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || m_axis_tready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_ch_reg    <= ch7_reg;
                out_level_reg <= res_level;
            end
            else
            begin
                skid_ch_reg    <= ch7_reg;
                skid_level_reg <= res_level;
            end
        end
        else if (pop && skid_valid_reg)
        begin
            out_ch_reg    <= skid_ch_reg;
            out_level_reg <= skid_level_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-OUT_W){1'b0}}, out_level_reg};
    assign m_axis_tuser  = {{(8-CH_W){1'b0}}, out_ch_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_stage1_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ch1_reg < CH_W'(tmac_pkg::CHANNELS))
        else $error("out-of-range channel entered the pipeline");

    a_count_below_set: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v1_reg) |-> stat_next.cnt < CNT_W'(tmac_pkg::SAMPLES_PER_SET - 1) + 1'b1)
        else $error("stored sample count reached a full set");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_level_reg != $signed({1'b1, {(OUT_W-1){1'b0}}}))
        else $error("reported level outside the symmetric range");

    a_stall_holds_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> skid_valid_reg && $stable(skid_level_reg))
        else $error("stalled skid result changed");

endmodule
